/* sv/plpm_pkg.sv */
`timescale 1ns / 1ps

package plpm_pkg;

    // fixed point and field widths
    localparam int FRAC_BITS  = 16;
    localparam int MAX_BLOCKS = 64;
    localparam int POS_W      = 31;
    localparam int VEL_W      = 32;
    localparam int BLK_W      = 6;
    localparam int CNT_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // datapath widths
    localparam int PROD_W = 64;                 // full 32x32 product
    localparam int DU_W   = PROD_W - FRAC_BITS; // product after the floor shift
    localparam int UX_W   = POS_W + 3;          // unwrapped position, signed
    localparam int LO_W   = BLK_W + POS_W;      // lower block bound
    localparam int HI_W   = LO_W + 1;           // upper block bound
    localparam int CMP_W  = HI_W + 1;           // signed compare width
    localparam int NUM_W  = POS_W + 1;          // remainder dividend

    // pipelined remainder unit
    localparam int REM_STEP   = 2;
    localparam int REM_STAGES = NUM_W / REM_STEP;

    // pipeline depth ahead of the remainder unit
    localparam int PRE_STAGES = 5;
    localparam int PIPE_DEPTH = PRE_STAGES + REM_STAGES;

    // reset values
    localparam logic [POS_W-1:0] ONE_Q = POS_W'(1) << FRAC_BITS;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KICK     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_W  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_H  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_X = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_Y = 3'd7;

    // result fields that ride alongside the remainder unit
    typedef struct packed {
        logic [POS_W-1:0]        pos_x;
        logic [POS_W-1:0]        pos_y;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic [BLK_W-1:0]        dest_x;
        logic [BLK_W-1:0]        dest_y;
        logic                    moved;
        logic                    too_fast;
    } t_side;

endpackage

/* sv/plpm_rem.sv */
`timescale 1ns / 1ps

module plpm_rem (
    input  logic                                       i_clk,
    input  logic [plpm_pkg::REM_STAGES-1:0]            i_en,
    input  logic [plpm_pkg::NUM_W-1:0]                 i_num,
    input  logic [plpm_pkg::POS_W-1:0]                 i_den,
    output logic [plpm_pkg::POS_W-1:0]                 o_rem
);
    import plpm_pkg::*;

    logic [POS_W-1:0] r_rem [REM_STAGES];
    logic [NUM_W-1:0] r_num [REM_STAGES];
    logic [POS_W-1:0] n_rem [REM_STAGES];
    logic [NUM_W-1:0] n_num [REM_STAGES];

    // restoring remainder, REM_STEP dividend bits per stage, msb first
    always_comb begin
        logic [POS_W-1:0] v_rem;
        logic [NUM_W-1:0] v_num;
        logic [POS_W:0]   v_t;
        for (int s = 0; s < REM_STAGES; s++) begin
            v_rem = (s == 0) ? '0 : r_rem[(s == 0) ? 0 : s - 1];
            v_num = (s == 0) ? i_num : r_num[(s == 0) ? 0 : s - 1];
            for (int b = 0; b < REM_STEP; b++) begin
                v_t = {v_rem, v_num[NUM_W-1-b]};
                if (v_t >= {1'b0, i_den}) begin
                    v_t = v_t - {1'b0, i_den};
                end
                v_rem = v_t[POS_W-1:0];
            end
            n_rem[s] = v_rem;
            n_num[s] = v_num << REM_STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < REM_STAGES; s++) begin
            if (i_en[s]) begin
                r_rem[s] <= n_rem[s];
                r_num[s] <= n_num[s];
            end
        end
    end

    assign o_rem = r_rem[REM_STAGES-1];

endmodule

/* sv/particle_leapfrog_push_migrate.sv */
`timescale 1ns / 1ps
// a request passes 5 push stages and then 16 remainder stages before its result is valid
// throughput: one particle per cycle while the output is taken; a stage loads when it or any later stage is empty
// the depth is set by the periodic wrap, a remainder unit that retires 2 dividend bits per stage
// reset: synchronous, active low; clears all stage valid bits and loads register defaults
// (kick and step 0, lengths and block sizes 1.0, block counts 1)

module particle_leapfrog_push_migrate (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // register writes
    input  logic                                i_cfg_we,
    input  logic [plpm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [plpm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // particle requests
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [plpm_pkg::POS_W-1:0]          i_pos_x,
    input  logic [plpm_pkg::POS_W-1:0]          i_pos_y,
    input  logic signed [plpm_pkg::VEL_W-1:0]   i_vel_x,
    input  logic signed [plpm_pkg::VEL_W-1:0]   i_vel_y,
    input  logic signed [plpm_pkg::VEL_W-1:0]   i_field_x,
    input  logic signed [plpm_pkg::VEL_W-1:0]   i_field_y,
    input  logic [plpm_pkg::BLK_W-1:0]          i_cur_block_x,
    input  logic [plpm_pkg::BLK_W-1:0]          i_cur_block_y,
    // pushed particles
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [plpm_pkg::POS_W-1:0]          o_new_pos_x,
    output logic [plpm_pkg::POS_W-1:0]          o_new_pos_y,
    output logic signed [plpm_pkg::VEL_W-1:0]   o_new_vel_x,
    output logic signed [plpm_pkg::VEL_W-1:0]   o_new_vel_y,
    output logic [plpm_pkg::BLK_W-1:0]          o_dest_block_x,
    output logic [plpm_pkg::BLK_W-1:0]          o_dest_block_y,
    output logic                                o_moved,
    output logic                                o_too_fast
);
    import plpm_pkg::*;

    // input fields plus the current block reduced modulo the block count
    typedef struct packed {
        logic [POS_W-1:0]        pos_x;
        logic [POS_W-1:0]        pos_y;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic [BLK_W-1:0]        cur_x;
        logic [BLK_W-1:0]        cur_y;
        logic [BLK_W-1:0]        red_x;
        logic [BLK_W-1:0]        red_y;
    } t_carry;

    //------------------------------------------------------------------
    // helpers
    //------------------------------------------------------------------

    // a length or size written as zero behaves as one lsb
    function automatic logic [POS_W-1:0] f_len(input logic [CFG_DATA_W-1:0] d);
        return (d[POS_W-1:0] == '0) ? POS_W'(1) : d[POS_W-1:0];
    endfunction

    // block count clamped into 1..MAX_BLOCKS
    function automatic logic [CNT_W-1:0] f_cnt(input logic [CFG_DATA_W-1:0] d);
        logic [CNT_W-1:0] v;
        v = d[CNT_W-1:0];
        if (v == '0) begin
            return CNT_W'(1);
        end else if (v > CNT_W'(MAX_BLOCKS)) begin
            return CNT_W'(MAX_BLOCKS);
        end
        return v;
    endfunction

    // block index modulo the count, one restoring step per index bit
    function automatic logic [BLK_W-1:0] f_mod(input logic [BLK_W-1:0] c,
                                               input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] t;
        logic [BLK_W-1:0] rem;
        rem = '0;
        for (int b = BLK_W - 1; b >= 0; b--) begin
            t = {rem, c[b]};
            if (t >= n) begin
                t = t - n;
            end
            rem = t[BLK_W-1:0];
        end
        return rem;
    endfunction

    // velocity plus floored kick, saturated to the signed velocity range
    function automatic logic signed [VEL_W-1:0] f_sat_add(
        input logic signed [VEL_W-1:0] v,
        input logic signed [DU_W-1:0]  du
    );
        logic signed [DU_W:0] s;
        s = {{(DU_W + 1 - VEL_W){v[VEL_W-1]}}, v} + {du[DU_W-1], du};
        if (s[DU_W:VEL_W-1] == '0 || s[DU_W:VEL_W-1] == '1) begin
            return s[VEL_W-1:0];
        end else if (s[DU_W]) begin
            return {1'b1, {(VEL_W - 1){1'b0}}};
        end
        return {1'b0, {(VEL_W - 1){1'b1}}};
    endfunction

    // one block step with wraparound, from an already reduced index
    function automatic logic [BLK_W-1:0] f_adj(input logic [BLK_W-1:0] cr,
                                               input logic dn,
                                               input logic up,
                                               input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] nm1;
        logic [CNT_W-1:0] cp1;
        nm1 = n - CNT_W'(1);
        cp1 = {1'b0, cr} + CNT_W'(1);
        if (dn) begin
            return (cr == '0) ? nm1[BLK_W-1:0] : cr - BLK_W'(1);
        end else if (up) begin
            return (cp1 == n) ? '0 : cp1[BLK_W-1:0];
        end
        return cr;
    endfunction

    //------------------------------------------------------------------
    // configuration registers, stored already normalized
    //------------------------------------------------------------------
    logic signed [VEL_W-1:0] r_kick;
    logic [POS_W-1:0]        r_step;
    logic [POS_W-1:0]        r_len_x;
    logic [POS_W-1:0]        r_len_y;
    logic [POS_W-1:0]        r_block_w;
    logic [POS_W-1:0]        r_block_h;
    logic [CNT_W-1:0]        r_blocks_x;
    logic [CNT_W-1:0]        r_blocks_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kick     <= '0;
            r_step     <= '0;
            r_len_x    <= ONE_Q;
            r_len_y    <= ONE_Q;
            r_block_w  <= ONE_Q;
            r_block_h  <= ONE_Q;
            r_blocks_x <= CNT_W'(1);
            r_blocks_y <= CNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KICK:     r_kick     <= i_cfg_data;
                CFG_STEP:     r_step     <= i_cfg_data[POS_W-1:0];
                CFG_LEN_X:    r_len_x    <= f_len(i_cfg_data);
                CFG_LEN_Y:    r_len_y    <= f_len(i_cfg_data);
                CFG_BLOCK_W:  r_block_w  <= f_len(i_cfg_data);
                CFG_BLOCK_H:  r_block_h  <= f_len(i_cfg_data);
                CFG_BLOCKS_X: r_blocks_x <= f_cnt(i_cfg_data);
                CFG_BLOCKS_Y: r_blocks_y <= f_cnt(i_cfg_data);
            endcase
        end
    end

    //------------------------------------------------------------------
    // stage flow control
    // a stage may load when it is empty or when some stage downstream of it
    // is empty or the output is being taken, so bubbles collapse and a
    // waiting result does not block new requests
    //------------------------------------------------------------------
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH-1:0] n_vld;
    logic [PIPE_DEPTH-1:0] rdy;

    always_comb begin
        for (int k = 0; k < PIPE_DEPTH; k++) begin
            rdy[k] = i_out_ready || (((~r_vld) >> k) != '0);
        end
        n_vld[0] = rdy[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < PIPE_DEPTH; k++) begin
            n_vld[k] = rdy[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = rdy[0];
    assign o_out_valid = r_vld[PIPE_DEPTH-1];

    //------------------------------------------------------------------
    // stage 0: kick products, block index reduced modulo the count
    //------------------------------------------------------------------
    t_carry                   r0_c;
    logic signed [PROD_W-1:0] r0_kf_x;
    logic signed [PROD_W-1:0] r0_kf_y;

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r0_c.pos_x <= i_pos_x;
            r0_c.pos_y <= i_pos_y;
            r0_c.vel_x <= i_vel_x;
            r0_c.vel_y <= i_vel_y;
            r0_c.cur_x <= i_cur_block_x;
            r0_c.cur_y <= i_cur_block_y;
            r0_c.red_x <= f_mod(i_cur_block_x, r_blocks_x);
            r0_c.red_y <= f_mod(i_cur_block_y, r_blocks_y);
            r0_kf_x    <= r_kick * i_field_x;
            r0_kf_y    <= r_kick * i_field_y;
        end
    end

    //------------------------------------------------------------------
    // stage 1: floor shift of the kick, saturating velocity update
    //------------------------------------------------------------------
    t_carry                  r1_c;
    logic signed [VEL_W-1:0] r1_nv_x;
    logic signed [VEL_W-1:0] r1_nv_y;

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r1_c    <= r0_c;
            r1_nv_x <= f_sat_add(r0_c.vel_x, r0_kf_x[PROD_W-1:FRAC_BITS]);
            r1_nv_y <= f_sat_add(r0_c.vel_y, r0_kf_y[PROD_W-1:FRAC_BITS]);
        end
    end

    //------------------------------------------------------------------
    // stage 2: displacement products, lower block bounds
    //------------------------------------------------------------------
    t_carry                   r2_c;
    logic signed [VEL_W-1:0]  r2_nv_x;
    logic signed [VEL_W-1:0]  r2_nv_y;
    logic signed [PROD_W-1:0] r2_sv_x;
    logic signed [PROD_W-1:0] r2_sv_y;
    logic [LO_W-1:0]          r2_lo_x;
    logic [LO_W-1:0]          r2_lo_y;

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r2_c    <= r1_c;
            r2_nv_x <= r1_nv_x;
            r2_nv_y <= r1_nv_y;
            r2_sv_x <= $signed({1'b0, r_step}) * r1_nv_x;
            r2_sv_y <= $signed({1'b0, r_step}) * r1_nv_y;
            r2_lo_x <= r1_c.cur_x * r_block_w;
            r2_lo_y <= r1_c.cur_y * r_block_h;
        end
    end

    //------------------------------------------------------------------
    // stage 3: too-fast check, unwrapped position, upper block bounds
    //------------------------------------------------------------------
    logic signed [DU_W-1:0] dx;
    logic signed [DU_W-1:0] dy;
    logic signed [DU_W-1:0] lim_x;
    logic signed [DU_W-1:0] lim_y;
    logic                   fast;

    assign dx    = r2_sv_x[PROD_W-1:FRAC_BITS];
    assign dy    = r2_sv_y[PROD_W-1:FRAC_BITS];
    assign lim_x = $signed({{(DU_W - POS_W){1'b0}}, r_len_x});
    assign lim_y = $signed({{(DU_W - POS_W){1'b0}}, r_len_y});
    // |d| > len on either axis
    assign fast  = (dx > lim_x) || (dx < -lim_x) || (dy > lim_y) || (dy < -lim_y);

    t_carry                  r3_c;
    logic signed [VEL_W-1:0] r3_nv_x;
    logic signed [VEL_W-1:0] r3_nv_y;
    logic                    r3_fast;
    logic signed [UX_W-1:0]  r3_ux;
    logic signed [UX_W-1:0]  r3_uy;
    logic [LO_W-1:0]         r3_lo_x;
    logic [LO_W-1:0]         r3_lo_y;
    logic [HI_W-1:0]         r3_hi_x;
    logic [HI_W-1:0]         r3_hi_y;

    // the unwrapped position only matters when the step is in range, and then
    // it fits UX_W bits, so the displacement is cut to that width
    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r3_c    <= r2_c;
            r3_nv_x <= r2_nv_x;
            r3_nv_y <= r2_nv_y;
            r3_fast <= fast;
            r3_ux   <= {{(UX_W - POS_W){1'b0}}, r2_c.pos_x} + dx[UX_W-1:0];
            r3_uy   <= {{(UX_W - POS_W){1'b0}}, r2_c.pos_y} + dy[UX_W-1:0];
            r3_lo_x <= r2_lo_x;
            r3_lo_y <= r2_lo_y;
            r3_hi_x <= {1'b0, r2_lo_x} + {{(HI_W - POS_W){1'b0}}, r_block_w};
            r3_hi_y <= {1'b0, r2_lo_y} + {{(HI_W - POS_W){1'b0}}, r_block_h};
        end
    end

    //------------------------------------------------------------------
    // stage 4: block side, destination block, dividend for the wrap
    //------------------------------------------------------------------
    logic signed [CMP_W-1:0] ux_e, uy_e;
    logic                    dn_x, up_x, dn_y, up_y, any_step;
    logic [BLK_W-1:0]        dst_x, dst_y;
    logic [UX_W-1:0]         ux_p, uy_p;
    t_side                   side4;

    always_comb begin
        ux_e = {{(CMP_W - UX_W){r3_ux[UX_W-1]}}, r3_ux};
        uy_e = {{(CMP_W - UX_W){r3_uy[UX_W-1]}}, r3_uy};
        dn_x = ux_e < $signed({{(CMP_W - LO_W){1'b0}}, r3_lo_x});
        up_x = ux_e >= $signed({{(CMP_W - HI_W){1'b0}}, r3_hi_x});
        dn_y = uy_e < $signed({{(CMP_W - LO_W){1'b0}}, r3_lo_y});
        up_y = uy_e >= $signed({{(CMP_W - HI_W){1'b0}}, r3_hi_y});
        any_step = dn_x || up_x || dn_y || up_y;

        // any step on either axis re-reduces both indexes
        dst_x = any_step ? f_adj(r3_c.red_x, dn_x, up_x, r_blocks_x) : r3_c.cur_x;
        dst_y = any_step ? f_adj(r3_c.red_y, dn_y, up_y, r_blocks_y) : r3_c.cur_y;

        // a negative unwrapped position is never below -len, so one add wraps it
        ux_p = r3_ux + {{(UX_W - POS_W){1'b0}}, r_len_x};
        uy_p = r3_uy + {{(UX_W - POS_W){1'b0}}, r_len_y};

        // too fast: the particle goes out as it came in
        side4.pos_x    = r3_c.pos_x;
        side4.pos_y    = r3_c.pos_y;
        side4.vel_x    = r3_fast ? r3_c.vel_x : r3_nv_x;
        side4.vel_y    = r3_fast ? r3_c.vel_y : r3_nv_y;
        side4.dest_x   = r3_fast ? r3_c.cur_x : dst_x;
        side4.dest_y   = r3_fast ? r3_c.cur_y : dst_y;
        side4.moved    = !r3_fast && ((dst_x != r3_c.cur_x) || (dst_y != r3_c.cur_y));
        side4.too_fast = r3_fast;
    end

    t_side            r4_side;
    logic [NUM_W-1:0] r4_num_x;
    logic [NUM_W-1:0] r4_num_y;

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r4_side  <= side4;
            r4_num_x <= r3_ux[UX_W-1] ? ux_p[NUM_W-1:0] : r3_ux[NUM_W-1:0];
            r4_num_y <= r3_uy[UX_W-1] ? uy_p[NUM_W-1:0] : r3_uy[NUM_W-1:0];
        end
    end

    //------------------------------------------------------------------
    // stages 5 and up: periodic wrap, position modulo the domain length
    //------------------------------------------------------------------
    logic [POS_W-1:0] rem_x;
    logic [POS_W-1:0] rem_y;

    plpm_rem u_rem_x (
        .i_clk (i_clk),
        .i_en  (rdy[PIPE_DEPTH-1:PRE_STAGES]),
        .i_num (r4_num_x),
        .i_den (r_len_x),
        .o_rem (rem_x)
    );

    plpm_rem u_rem_y (
        .i_clk (i_clk),
        .i_en  (rdy[PIPE_DEPTH-1:PRE_STAGES]),
        .i_num (r4_num_y),
        .i_den (r_len_y),
        .o_rem (rem_y)
    );

    // the other result fields travel alongside the remainder stages
    t_side r_side [REM_STAGES];

    always_ff @(posedge i_clk) begin
        if (rdy[PRE_STAGES]) begin
            r_side[0] <= r4_side;
        end
        for (int s = 1; s < REM_STAGES; s++) begin
            if (rdy[PRE_STAGES+s]) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    //------------------------------------------------------------------
    // result
    //------------------------------------------------------------------
    t_side out_side;

    assign out_side       = r_side[REM_STAGES-1];
    assign o_new_pos_x    = out_side.too_fast ? out_side.pos_x : rem_x;
    assign o_new_pos_y    = out_side.too_fast ? out_side.pos_y : rem_y;
    assign o_new_vel_x    = out_side.vel_x;
    assign o_new_vel_y    = out_side.vel_y;
    assign o_dest_block_x = out_side.dest_x;
    assign o_dest_block_y = out_side.dest_y;
    assign o_moved        = out_side.moved;
    assign o_too_fast     = out_side.too_fast;

`ifndef SYNTHESIS
    // a too-fast particle never migrates
    a_fast_no_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_too_fast) |-> !o_moved)
        else $error("too-fast particle flagged as moved");

    // an empty pipeline always takes a request
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld == '0) |-> o_in_ready)
        else $error("empty pipeline refuses a request");

    // a taken output frees the whole chain
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("request stalled while output is taken");

    // an accepted request lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n) && $past(i_in_valid && o_in_ready)) |-> r_vld[0])
        else $error("accepted request lost at the first stage");
`endif

endmodule

/* tb/particle_leapfrog_push_migrate_test.sv */
`timescale 1ns / 1ps

import plpm_pkg::*;

localparam longint VEL_MAX  = 64'sd2147483647;
localparam longint VEL_MIN  = -64'sd2147483648;
localparam int     NUM_REGS = 8;

typedef struct packed {
    logic [POS_W-1:0]        pos_x;
    logic [POS_W-1:0]        pos_y;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] field_x;
    logic signed [VEL_W-1:0] field_y;
    logic [BLK_W-1:0]        cur_x;
    logic [BLK_W-1:0]        cur_y;
} t_particle;

typedef struct packed {
    logic [POS_W-1:0]        new_pos_x;
    logic [POS_W-1:0]        new_pos_y;
    logic signed [VEL_W-1:0] new_vel_x;
    logic signed [VEL_W-1:0] new_vel_y;
    logic [BLK_W-1:0]        dest_x;
    logic [BLK_W-1:0]        dest_y;
    logic                    moved;
    logic                    too_fast;
} t_result;

// a length or size of zero behaves as one
function automatic longint size_or_one(longint v);
    return (v == 0) ? 64'sd1 : v;
endfunction

function automatic longint count_clamped(longint v);
    if (v == 0) return 64'sd1;
    if (v > MAX_BLOCKS) return longint'(MAX_BLOCKS);
    return v;
endfunction

function automatic longint saturate_vel(longint v);
    if (v > VEL_MAX) return VEL_MAX;
    if (v < VEL_MIN) return VEL_MIN;
    return v;
endfunction

class push_scoreboard;
    longint    kick_q, step_q, len_x_q, len_y_q, blk_w_q, blk_h_q, cnt_x_q, cnt_y_q;
    t_result   pushed_q[$];
    int unsigned mismatches;

    function new();
        kick_q     = 0;
        step_q     = 0;
        len_x_q    = longint'(ONE_Q);
        len_y_q    = longint'(ONE_Q);
        blk_w_q    = longint'(ONE_Q);
        blk_h_q    = longint'(ONE_Q);
        cnt_x_q    = 1;
        cnt_y_q    = 1;
        mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_KICK:     kick_q  = longint'(signed'(value));
            CFG_STEP:     step_q  = longint'(value[POS_W-1:0]);
            CFG_LEN_X:    len_x_q = longint'(value[POS_W-1:0]);
            CFG_LEN_Y:    len_y_q = longint'(value[POS_W-1:0]);
            CFG_BLOCK_W:  blk_w_q = longint'(value[POS_W-1:0]);
            CFG_BLOCK_H:  blk_h_q = longint'(value[POS_W-1:0]);
            CFG_BLOCKS_X: cnt_x_q = longint'(value[CNT_W-1:0]);
            CFG_BLOCKS_Y: cnt_y_q = longint'(value[CNT_W-1:0]);
            default: ;
        endcase
    endfunction

    function int block_side(longint pos, longint cur, longint size);
        if (pos < cur * size) return -1;
        if (pos >= cur * size + size) return 1;
        return 0;
    endfunction

    function longint wrap_pos(longint pos, longint len);
        longint r;
        r = pos % len;
        if (r < 0) r += len;
        return r;
    endfunction

    function t_result predict_push(t_particle p);
        t_result r;
        longint  px, py, cx, cy, nvx, nvy, dx, dy, ux, uy;
        longint  lx, ly, bw, bh, nx, ny, jx, jy;
        int      sx, sy;
        px  = longint'(p.pos_x);
        py  = longint'(p.pos_y);
        cx  = longint'(p.cur_x);
        cy  = longint'(p.cur_y);
        lx  = size_or_one(len_x_q);
        ly  = size_or_one(len_y_q);
        bw  = size_or_one(blk_w_q);
        bh  = size_or_one(blk_h_q);
        nx  = count_clamped(cnt_x_q);
        ny  = count_clamped(cnt_y_q);
        // kick, then drift with the new velocity; shifts floor toward minus infinity
        nvx = saturate_vel(longint'(signed'(p.vel_x))
                           + ((kick_q * longint'(signed'(p.field_x))) >>> FRAC_BITS));
        nvy = saturate_vel(longint'(signed'(p.vel_y))
                           + ((kick_q * longint'(signed'(p.field_y))) >>> FRAC_BITS));
        dx  = (step_q * nvx) >>> FRAC_BITS;
        dy  = (step_q * nvy) >>> FRAC_BITS;
        if (((dx < 0) ? -dx : dx) > lx || ((dy < 0) ? -dy : dy) > ly) begin
            r.new_pos_x = p.pos_x;
            r.new_pos_y = p.pos_y;
            r.new_vel_x = p.vel_x;
            r.new_vel_y = p.vel_y;
            r.dest_x    = p.cur_x;
            r.dest_y    = p.cur_y;
            r.moved     = 1'b0;
            r.too_fast  = 1'b1;
            return r;
        end
        ux = px + dx;
        uy = py + dy;
        sx = block_side(ux, cx, bw);
        sy = block_side(uy, cy, bh);
        jx = cx;
        jy = cy;
        if (sx != 0 || sy != 0) begin
            jx = (cx + sx + nx) % nx;
            jy = (cy + sy + ny) % ny;
        end
        r.new_pos_x = POS_W'(wrap_pos(ux, lx));
        r.new_pos_y = POS_W'(wrap_pos(uy, ly));
        r.new_vel_x = VEL_W'(nvx);
        r.new_vel_y = VEL_W'(nvy);
        r.dest_x    = BLK_W'(jx);
        r.dest_y    = BLK_W'(jy);
        r.moved     = (jx != cx || jy != cy);
        r.too_fast  = 1'b0;
        return r;
    endfunction

    function void note_request(t_particle p);
        pushed_q.push_back(predict_push(p));
    endfunction

    function int pending();
        return pushed_q.size();
    endfunction

    task report(string what, longint got, longint want);
        mismatches++;
        $display("%0t %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task check_result(t_result got);
        t_result want;
        if (pushed_q.size() == 0) begin
            report("result with no request outstanding", longint'(got.new_pos_x), 0);
            return;
        end
        want = pushed_q.pop_front();
        if (got.new_pos_x !== want.new_pos_x)
            report("new_pos_x", longint'(got.new_pos_x), longint'(want.new_pos_x));
        if (got.new_pos_y !== want.new_pos_y)
            report("new_pos_y", longint'(got.new_pos_y), longint'(want.new_pos_y));
        if (got.new_vel_x !== want.new_vel_x)
            report("new_vel_x", longint'(got.new_vel_x), longint'(want.new_vel_x));
        if (got.new_vel_y !== want.new_vel_y)
            report("new_vel_y", longint'(got.new_vel_y), longint'(want.new_vel_y));
        if (got.dest_x !== want.dest_x)
            report("dest_block_x", longint'(got.dest_x), longint'(want.dest_x));
        if (got.dest_y !== want.dest_y)
            report("dest_block_y", longint'(got.dest_y), longint'(want.dest_y));
        if (got.moved !== want.moved)
            report("moved", longint'(got.moved), longint'(want.moved));
        if (got.too_fast !== want.too_fast)
            report("too_fast", longint'(got.too_fast), longint'(want.too_fast));
    endtask
endclass

module particle_leapfrog_push_migrate_test;

    // cycles with no accepted request or result before giving up
    localparam int unsigned STALL_LIMIT = 2000;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data    = '0;
    logic                    i_in_valid    = 1'b0;
    logic                    o_in_ready;
    logic [POS_W-1:0]        i_pos_x       = '0;
    logic [POS_W-1:0]        i_pos_y       = '0;
    logic signed [VEL_W-1:0] i_vel_x       = '0;
    logic signed [VEL_W-1:0] i_vel_y       = '0;
    logic signed [VEL_W-1:0] i_field_x     = '0;
    logic signed [VEL_W-1:0] i_field_y     = '0;
    logic [BLK_W-1:0]        i_cur_block_x = '0;
    logic [BLK_W-1:0]        i_cur_block_y = '0;
    logic                    o_out_valid;
    logic                    i_out_ready   = 1'b0;
    logic [POS_W-1:0]        o_new_pos_x;
    logic [POS_W-1:0]        o_new_pos_y;
    logic signed [VEL_W-1:0] o_new_vel_x;
    logic signed [VEL_W-1:0] o_new_vel_y;
    logic [BLK_W-1:0]        o_dest_block_x;
    logic [BLK_W-1:0]        o_dest_block_y;
    logic                    o_moved;
    logic                    o_too_fast;

    push_scoreboard sb;
    int unsigned    send_idle = 21;     // percent of cycles the sender holds back
    int unsigned    recv_idle = 45;     // percent of cycles the receiver stalls
    int unsigned    stall_cycles = 0;

    particle_leapfrog_push_migrate dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_vel_x        (i_vel_x),
        .i_vel_y        (i_vel_y),
        .i_field_x      (i_field_x),
        .i_field_y      (i_field_y),
        .i_cur_block_x  (i_cur_block_x),
        .i_cur_block_y  (i_cur_block_y),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_new_pos_x    (o_new_pos_x),
        .o_new_pos_y    (o_new_pos_y),
        .o_new_vel_x    (o_new_vel_x),
        .o_new_vel_y    (o_new_vel_y),
        .o_dest_block_x (o_dest_block_x),
        .o_dest_block_y (o_dest_block_y),
        .o_moved        (o_moved),
        .o_too_fast     (o_too_fast)
    );

    // 20 ns period, low half first
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver backpressure, redrawn every falling edge
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // sample both handshakes at the rising edge; also the stall watchdog
    always @(posedge i_clk) begin
        t_particle req;
        t_result   res;
        logic      took_req;
        logic      took_res;
        if (i_rst_n) begin
            took_req = (i_in_valid === 1'b1) && (o_in_ready === 1'b1);
            took_res = (o_out_valid === 1'b1) && (i_out_ready === 1'b1);
            // note the request first so a result taken at the same edge would still find it
            if (took_req) begin
                req.pos_x   = i_pos_x;
                req.pos_y   = i_pos_y;
                req.vel_x   = i_vel_x;
                req.vel_y   = i_vel_y;
                req.field_x = i_field_x;
                req.field_y = i_field_y;
                req.cur_x   = i_cur_block_x;
                req.cur_y   = i_cur_block_y;
                sb.note_request(req);
            end
            if (took_res) begin
                res.new_pos_x = o_new_pos_x;
                res.new_pos_y = o_new_pos_y;
                res.new_vel_x = o_new_vel_x;
                res.new_vel_y = o_new_vel_y;
                res.dest_x    = o_dest_block_x;
                res.dest_y    = o_dest_block_y;
                res.moved     = o_moved;
                res.too_fast  = o_too_fast;
                sb.check_result(res);
            end
            if (took_req || took_res) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("particle_leapfrog_push_migrate: mismatch");
                    $finish;
                end
            end
        end
    end

    // one request; valid stays up from here until the next request or a drain
    task automatic send_particle(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                                 input logic [VEL_W-1:0] vx, input logic [VEL_W-1:0] vy,
                                 input logic [VEL_W-1:0] fx, input logic [VEL_W-1:0] fy,
                                 input logic [BLK_W-1:0] cx, input logic [BLK_W-1:0] cy);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_pos_x       <= px;
        i_pos_y       <= py;
        i_vel_x       <= vx;
        i_vel_y       <= vy;
        i_field_x     <= fx;
        i_field_y     <= fy;
        i_cur_block_x <= cx;
        i_cur_block_y <= cy;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
    endtask

    // stop sending and let every outstanding particle come back
    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // write all eight registers, only while nothing is in flight
    task automatic load_settings(input logic [CFG_DATA_W-1:0] kick,
                                 input logic [CFG_DATA_W-1:0] step,
                                 input logic [CFG_DATA_W-1:0] lx,
                                 input logic [CFG_DATA_W-1:0] ly,
                                 input logic [CFG_DATA_W-1:0] bw,
                                 input logic [CFG_DATA_W-1:0] bh,
                                 input logic [CFG_DATA_W-1:0] nx,
                                 input logic [CFG_DATA_W-1:0] ny);
        logic [CFG_DATA_W-1:0] v [NUM_REGS];
        v[CFG_KICK]     = kick;
        v[CFG_STEP]     = step;
        v[CFG_LEN_X]    = lx;
        v[CFG_LEN_Y]    = ly;
        v[CFG_BLOCK_W]  = bw;
        v[CFG_BLOCK_H]  = bh;
        v[CFG_BLOCKS_X] = nx;
        v[CFG_BLOCKS_Y] = ny;
        for (int i = 0; i < NUM_REGS; i++) begin
            @(negedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(i);
            i_cfg_data <= v[i];
            @(posedge i_clk);
            sb.set_reg(CFG_IDX_W'(i), v[i]);
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_extreme();
        case ($urandom_range(2))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // mostly legal counts, sometimes zero or above the maximum
    function automatic logic [CFG_DATA_W-1:0] pick_count();
        case ($urandom_range(9))
            0:       return '0;
            1:       return $urandom_range(127, 65);
            default: return $urandom_range(64, 1);
        endcase
    endfunction

    task automatic load_random_settings();
        logic [CFG_DATA_W-1:0] nx, ny, bw, bh, lx, ly, kick, step;
        if ($urandom_range(9) == 0) begin
            load_settings(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                          pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
        end else begin
            nx   = pick_count();
            ny   = pick_count();
            bw   = $urandom_range(1 << 22, 1 << 12);
            bh   = $urandom_range(1 << 22, 1 << 12);
            // usually a domain made of whole blocks, sometimes an arbitrary length
            lx   = ($urandom_range(3) == 0) ? $urandom_range(1 << 30, 1)
                                            : CFG_DATA_W'(count_clamped(nx) * bw);
            ly   = ($urandom_range(3) == 0) ? $urandom_range(1 << 30, 1)
                                            : CFG_DATA_W'(count_clamped(ny) * bh);
            kick = CFG_DATA_W'(int'($urandom_range(1 << 18)) - (1 << 17));
            step = $urandom_range(1 << 17);
            load_settings(kick, step, lx, ly, bw, bh, nx, ny);
        end
    endtask

    // velocity that moves the particle up to about one block either way
    function automatic longint velocity_for(longint size, longint st);
        longint span;
        longint target;
        span   = (size > (64'sd1 << 30)) ? (64'sd1 << 30) : size;
        target = longint'($urandom_range(2 * span)) - span;
        if (st == 0) return longint'($urandom_range(1 << 18)) - (64'sd1 << 17);
        return saturate_vel(target * (64'sd1 << FRAC_BITS) / st);
    endfunction

    task automatic send_random_particle(input bit well_formed);
        longint bw, bh, nx, ny, px, py, vx, vy;
        longint cx, cy;
        int     fx, fy;
        if (!well_formed) begin
            send_particle($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom_range(63), $urandom_range(63));
            return;
        end
        bw = size_or_one(sb.blk_w_q);
        bh = size_or_one(sb.blk_h_q);
        nx = count_clamped(sb.cnt_x_q);
        ny = count_clamped(sb.cnt_y_q);
        // start inside a real block so crossings and wraps happen often
        cx = longint'($urandom_range(nx - 1));
        cy = longint'($urandom_range(ny - 1));
        px = cx * bw + longint'($urandom_range(bw - 1));
        py = cy * bh + longint'($urandom_range(bh - 1));
        vx = velocity_for(bw, sb.step_q);
        vy = velocity_for(bh, sb.step_q);
        fx = ($urandom_range(3) == 0) ? int'($urandom)
                                      : int'($urandom_range(1 << 17)) - (1 << 16);
        fy = ($urandom_range(3) == 0) ? int'($urandom)
                                      : int'($urandom_range(1 << 17)) - (1 << 16);
        send_particle(POS_W'(px), POS_W'(py), VEL_W'(vx), VEL_W'(vy), fx, fy,
                      BLK_W'(cx), BLK_W'(cy));
    endtask

    initial begin
        sb = new();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: no kick, no drift, one unit block
        send_particle('0, '0, '0, '0, '0, '0, '0, '0);
        send_particle(31'h0000_8000, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h8000_0000, 6'd0, 6'd63);
        wait_for_results();

        // 4x4 blocks of 16.0 in a 64.0 domain, unit kick and step
        load_settings(32'h0001_0000, 32'h0001_0000, 32'h0040_0000, 32'h0040_0000,
                      32'h0010_0000, 32'h0010_0000, 32'd4, 32'd4);
        send_particle('0, '0, '0, '0, '0, '0, '0, '0);
        // crossing +x
        send_particle(31'h000F_8000, 31'h0008_0000, 32'h0000_C000, '0, '0, '0, 6'd0, 6'd0);
        // crossing -x below zero, wraps in position and block
        send_particle(31'h0000_4000, 31'h0008_0000, 32'hFFFF_8000, '0, '0, '0, 6'd0, 6'd0);
        // -x and +y at once, y wraps
        send_particle(31'h0010_2000, 31'h003F_F000, 32'hFFFF_C000, 32'h0000_2000,
                      '0, '0, 6'd1, 6'd3);
        // kick from the field alone
        send_particle(31'h0005_0000, 31'h0005_0000, '0, '0, 32'h0002_0000, 32'hFFFE_0000,
                      6'd0, 6'd0);
        // smallest negative field floors to minus one lsb
        send_particle('0, '0, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0, 6'd0);
        // too fast along x, then along y
        send_particle(31'h0001_0000, 31'h0001_0000, 32'h0064_0000, '0, '0, '0, 6'd0, 6'd0);
        send_particle(31'h0001_0000, 31'h0001_0000, '0, 32'hFFB0_0000, '0, '0, 6'd0, 6'd0);
        // displacement exactly one domain length is still pushed
        send_particle(31'h0002_0000, 31'h0002_0000, 32'h0040_0000, 32'hFFC0_0000,
                      '0, '0, 6'd0, 6'd0);
        // positions beyond the domain with out of range blocks; the first block stays put
        send_particle(31'h0064_0000, 31'h0008_0000, '0, '0, '0, '0, 6'd6, 6'd0);
        send_particle(31'h7FFF_FFFF, 31'h7FFF_FFFF, '0, '0, '0, '0, 6'd63, 6'd63);
        // out of range block that steps and gets reduced
        send_particle('0, '0, '0, '0, '0, '0, 6'd10, 6'd0);
        // field extremes with saturation
        send_particle(31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 6'd63, 6'd63);
        send_particle('0, '0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      6'd0, 6'd0);
        wait_for_results();

        // all zero registers: sizes and counts act as one, most negative kick
        load_settings(32'h8000_0000, '0, '0, '0, '0, '0, '0, '0);
        send_particle('0, '0, '0, '0, '0, '0, '0, '0);
        send_particle(31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 6'd63, 6'd63);
        send_particle(31'h1234_5678, 31'h0765_4321, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 32'h7FFF_FFFF, 6'd21, 6'd42);
        wait_for_results();

        // all registers at their top, counts above the maximum
        load_settings(32'h7FFF_FFFF, '1, '1, '1, '1, '1, '1, 32'd65);
        send_particle('0, '0, '0, '0, '0, '0, '0, '0);
        send_particle('0, '0, 32'd1, 32'd1, '0, '0, 6'd0, 6'd0);
        send_particle('0, '0, 32'h7FFF_FFFF, '0, '0, '0, 6'd0, 6'd0);
        send_particle(31'h7FFF_FFFF, '0, '0, '0, '0, '0, 6'd0, 6'd0);
        send_particle('0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0, 6'd0, 6'd0);

        // random traffic in three idle profiles, five settings each
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin send_idle = 21; recv_idle = 45; end
                1:       begin send_idle = 45; recv_idle = 21; end
                default: begin send_idle = 0;  recv_idle = 0;  end
            endcase
            for (int seg = 0; seg < 5; seg++) begin
                wait_for_results();
                load_random_settings();
                for (int k = 0; k < 110; k++) begin
                    // hold the sender until the pipeline has fully drained
                    if (seg == 2 && k == 55) wait_for_results();
                    send_random_particle($urandom_range(99) < 80);
                end
            end
        end

        wait_for_results();
        // catch anything that comes out late
        repeat (PIPE_DEPTH + 20) @(posedge i_clk);
        if (sb.pending() != 0) sb.report("results still missing", sb.pending(), 0);
        if (sb.mismatches == 0)
            $display("particle_leapfrog_push_migrate: match");
        else
            $display("particle_leapfrog_push_migrate: mismatch");
        $finish;
    end

endmodule
